// ===== hw/rtl/cpk_pkg.sv =====
// Shared types and constants for the 28-bit callsign codec.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package cpk_pkg;

  localparam int unsigned PACKED_W = 28;

  // Offset added to a standard callsign's mixed-radix number
  localparam logic [27:0] CALL_OFFSET = 28'd6257896;

  localparam int unsigned RADIX_LEAD  = 36;
  localparam int unsigned RADIX_DIGIT = 10;
  localparam int unsigned RADIX_TAIL  = 27;

  // Reciprocals for exact division by multiply and shift; each one holds over
  // the full range of its stage input (28, 24, 19, 14 and 11 bits).
  localparam int unsigned SH_27A = 33;
  localparam int unsigned SH_27B = 29;
  localparam int unsigned SH_27C = 24;
  localparam int unsigned SH_10  = 18;
  localparam int unsigned SH_36  = 17;

  localparam logic [28:0] RECIP_27A =
    29'((64'd1 << SH_27A) / 64'(RADIX_TAIL) + 64'd1);
  localparam logic [24:0] RECIP_27B =
    25'((64'd1 << SH_27B) / 64'(RADIX_TAIL) + 64'd1);
  localparam logic [19:0] RECIP_27C =
    20'((64'd1 << SH_27C) / 64'(RADIX_TAIL) + 64'd1);
  localparam logic [14:0] RECIP_10 =
    15'((64'd1 << SH_10) / 64'(RADIX_DIGIT) + 64'd1);
  localparam logic [11:0] RECIP_36 =
    12'((64'd1 << SH_36) / 64'(RADIX_LEAD) + 64'd1);

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_Z     = 8'h5A;

  // Six-character token fields, first character in the low byte
  localparam logic [5:0][7:0] TEXT_DE =
    {ASCII_SPACE, ASCII_SPACE, ASCII_SPACE, ASCII_SPACE, 8'h45, 8'h44};
  localparam logic [5:0][7:0] TEXT_QRZ =
    {ASCII_SPACE, ASCII_SPACE, ASCII_SPACE, 8'h5A, 8'h52, 8'h51};
  localparam logic [5:0][7:0] TEXT_CQ =
    {ASCII_SPACE, ASCII_SPACE, ASCII_SPACE, ASCII_SPACE, 8'h51, 8'h43};
  localparam logic [5:0][7:0] TEXT_BLANK = {6{ASCII_SPACE}};

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CQ_FORM  = 2'd1,
    ST_BAD_CHAR = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TOK_DE  = 2'd0,
    TOK_QRZ = 2'd1,
    TOK_CQ  = 2'd2
  } tok_t;

  // Control carried alongside the data down the pipeline
  typedef struct packed {
    kind_t   kind;
    status_t status;
    logic    tok;
    tok_t    tok_val;
  } cpk_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/callsign_pack_unpack_28bit.sv =====
// Top level of the 28-bit callsign codec: seven-stage pipeline with handshake.
// Depends on cpk_pkg, cpk_classify and cpk_assemble.
//
//   Channel  Dir  Accepted on            Payload
//   s_*      in   s_tvalid & s_tready    tdata: chars 0..5, in_packed; tuser: kind
//   m_*      out  m_tvalid & m_tready    tdata: out_packed, chars 0..5; tuser: status
//
// The result is presented on m_* after seven register stages; one transaction
// enters per cycle unless a stall on m_* holds the pipeline. The depth
// is set by the decode chain of five reciprocal divisions, one per stage,
// matched by the encode Horner steps.
// Each stage advances when it is empty or the stage after it advances, so a
// bubble is squeezed out and a stall holds the run of full stages next to m_*.
// rst is synchronous and clears only the valid bits.
`default_nettype none

module callsign_pack_unpack_28bit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // in_char0..in_char5 [47:0], in_packed [75:48]
  input  wire logic [0:0]  s_tuser,   // kind [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // out_packed [27:0], out_char0..out_char5 [75:28]
  output logic [1:0]       m_tuser    // status [1:0]
);

  localparam int unsigned NSTAGE = 7;

  logic [NSTAGE:1]   vld;
  logic [NSTAGE+1:1] rdy;
  logic [NSTAGE:1]   vin;

  always_comb begin
    rdy[NSTAGE+1] = m_tready;
    for (int i = NSTAGE; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    vin = {vld[NSTAGE-1:1], s_tvalid};
  end

  assign s_tready = rdy[1];
  assign m_tvalid = vld[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 1; i <= NSTAGE; i++) begin
        if (rdy[i]) begin
          vld[i] <= vin[i];
        end
      end
    end
  end

  // Stage 1 inputs
  logic [5:0][7:0]   in_chars;
  cpk_pkg::cpk_ctl_t ctl_c;
  logic [27:0]       n0_c;
  logic [10:0]       acc_c;
  logic [3:0]        k2_c;
  logic [4:0]        k3_c, k4_c, k5_c;

  assign in_chars = s_tdata[47:0];

  cpk_classify u_classify (
    .kind      (cpk_pkg::kind_t'(s_tuser[0])),
    .in_chars  (in_chars),
    .in_packed (s_tdata[75:48]),
    .ctl       (ctl_c),
    .n0        (n0_c),
    .acc       (acc_c),
    .k2        (k2_c),
    .k3        (k3_c),
    .k4        (k4_c),
    .k5        (k5_c)
  );

  // Pipeline registers, numbered by stage
  cpk_pkg::cpk_ctl_t ctl1, ctl2, ctl3, ctl4, ctl5, ctl6;
  logic [27:0] n0_1, n0_2;
  logic [10:0] acc1;
  logic [13:0] acc2;
  logic [18:0] acc3;
  logic [23:0] acc4;
  logic [27:0] acc5;
  logic [27:0] val6;
  logic [3:0]  k2_1;
  logic [4:0]  k3_1, k3_2;
  logic [4:0]  k4_1, k4_2, k4_3;
  logic [4:0]  k5_1, k5_2, k5_3, k5_4;
  logic [23:0] q1_2, q1_3;
  logic [18:0] q2_3, q2_4;
  logic [13:0] q3_4, q3_5;
  logic [10:0] q4_5, q4_6;
  logic [5:0]  q5_6;
  logic [4:0]  d5_3, d5_4, d5_5, d5_6;
  logic [4:0]  d4_4, d4_5, d4_6;
  logic [4:0]  d3_5, d3_6;
  logic [3:0]  d2_6;

  logic [56:0] prod1;
  logic [48:0] prod2;
  logic [38:0] prod3;
  logic [28:0] prod4;
  logic [22:0] prod5;

  // Reciprocal products, each from a registered operand
  always_comb begin
    prod1 = 57'(n0_1) * 57'(cpk_pkg::RECIP_27A);
    prod2 = 49'(q1_2) * 49'(cpk_pkg::RECIP_27B);
    prod3 = 39'(q2_3) * 39'(cpk_pkg::RECIP_27C);
    prod4 = 29'(q3_4) * 29'(cpk_pkg::RECIP_10);
    prod5 = 23'(q4_5) * 23'(cpk_pkg::RECIP_36);
  end

  logic [27:0]       out_packed_c;
  logic [5:0][7:0]   out_chars_c;
  cpk_pkg::status_t  status_c;
  logic [27:0]       out_packed_r;
  logic [5:0][7:0]   out_chars_r;
  cpk_pkg::status_t  status_r;

  cpk_assemble u_assemble (
    .ctl        (ctl6),
    .enc_value  (val6),
    .q4         (q4_6),
    .q5         (q5_6),
    .d2         (d2_6),
    .d3         (d3_6),
    .d4         (d4_6),
    .d5         (d5_6),
    .out_packed (out_packed_c),
    .out_chars  (out_chars_c),
    .status     (status_c)
  );

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ctl1 <= ctl_c;
      n0_1 <= n0_c;
      acc1 <= acc_c;
      k2_1 <= k2_c;
      k3_1 <= k3_c;
      k4_1 <= k4_c;
      k5_1 <= k5_c;
    end
    if (rdy[2]) begin
      ctl2 <= ctl1;
      n0_2 <= n0_1;
      q1_2 <= prod1[cpk_pkg::SH_27A +: 24];
      acc2 <= 14'(acc1) * 14'(cpk_pkg::RADIX_DIGIT) + 14'(k2_1);
      k3_2 <= k3_1;
      k4_2 <= k4_1;
      k5_2 <= k5_1;
    end
    if (rdy[3]) begin
      ctl3 <= ctl2;
      d5_3 <= 5'(n0_2 - 28'(q1_2) * 28'(cpk_pkg::RADIX_TAIL));
      q1_3 <= q1_2;
      q2_3 <= prod2[cpk_pkg::SH_27B +: 19];
      acc3 <= 19'(acc2) * 19'(cpk_pkg::RADIX_TAIL) + 19'(k3_2);
      k4_3 <= k4_2;
      k5_3 <= k5_2;
    end
    if (rdy[4]) begin
      ctl4 <= ctl3;
      d5_4 <= d5_3;
      d4_4 <= 5'(q1_3 - 24'(q2_3) * 24'(cpk_pkg::RADIX_TAIL));
      q2_4 <= q2_3;
      q3_4 <= prod3[cpk_pkg::SH_27C +: 14];
      acc4 <= 24'(acc3) * 24'(cpk_pkg::RADIX_TAIL) + 24'(k4_3);
      k5_4 <= k5_3;
    end
    if (rdy[5]) begin
      ctl5 <= ctl4;
      d5_5 <= d5_4;
      d4_5 <= d4_4;
      d3_5 <= 5'(q2_4 - 19'(q3_4) * 19'(cpk_pkg::RADIX_TAIL));
      q3_5 <= q3_4;
      q4_5 <= prod4[cpk_pkg::SH_10 +: 11];
      acc5 <= 28'(acc4) * 28'(cpk_pkg::RADIX_TAIL) + 28'(k5_4);
    end
    if (rdy[6]) begin
      ctl6 <= ctl5;
      d5_6 <= d5_5;
      d4_6 <= d4_5;
      d3_6 <= d3_5;
      d2_6 <= 4'(q3_5 - 14'(q4_5) * 14'(cpk_pkg::RADIX_DIGIT));
      q4_6 <= q4_5;
      q5_6 <= prod5[cpk_pkg::SH_36 +: 6];
      val6 <= acc5 + cpk_pkg::CALL_OFFSET;
    end
    if (rdy[7]) begin
      out_packed_r <= out_packed_c;
      out_chars_r  <= out_chars_c;
      status_r     <= status_c;
    end
  end

  assign m_tdata = {4'b0000, out_chars_r, out_packed_r};
  assign m_tuser = status_r;

  // An empty output stage must open the whole pipeline to new transactions
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage empty");

  // Any error or unused status carries a zero packed value
  a_err_packed_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status_r != cpk_pkg::ST_OK) |-> (out_packed_r == 28'd0))
    else $error("non-zero packed value with error status");

  // Encode-only errors never come with characters
  a_enc_err_no_chars: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status_r == cpk_pkg::ST_CQ_FORM || status_r == cpk_pkg::ST_BAD_CHAR))
      |-> (out_chars_r == '0))
    else $error("characters present with encode error");

endmodule

`default_nettype wire

// ===== hw/rtl/cpk_classify.sv =====
// Front stage logic: character index lookup, token and error detection,
// first Horner step of the encode, offset removal for decode. Uses cpk_pkg.
`default_nettype none

module cpk_classify (
  input  var cpk_pkg::kind_t   kind,
  input  wire logic [5:0][7:0] in_chars,
  input  wire logic [27:0]     in_packed,
  output cpk_pkg::cpk_ctl_t    ctl,
  output logic [27:0]          n0,
  output logic [10:0]          acc,
  output logic [3:0]           k2,
  output logic [4:0]           k3,
  output logic [4:0]           k4,
  output logic [4:0]           k5
);

  // Each lookup returns {in_set, index}
  function automatic logic [6:0] idx_sp_alnum(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c == cpk_pkg::ASCII_SPACE) begin
      r = {1'b1, 6'd0};
    end else if (c >= cpk_pkg::ASCII_0 && c <= cpk_pkg::ASCII_9) begin
      r = {1'b1, 6'(c - 8'd47)};
    end else if (c >= cpk_pkg::ASCII_A && c <= cpk_pkg::ASCII_Z) begin
      r = {1'b1, 6'(c - 8'd54)};
    end
    return r;
  endfunction

  function automatic logic [6:0] idx_alnum(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= cpk_pkg::ASCII_0 && c <= cpk_pkg::ASCII_9) begin
      r = {1'b1, 6'(c - cpk_pkg::ASCII_0)};
    end else if (c >= cpk_pkg::ASCII_A && c <= cpk_pkg::ASCII_Z) begin
      r = {1'b1, 6'(c - 8'd55)};
    end
    return r;
  endfunction

  function automatic logic [4:0] idx_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= cpk_pkg::ASCII_0 && c <= cpk_pkg::ASCII_9) begin
      r = {1'b1, 4'(c - cpk_pkg::ASCII_0)};
    end
    return r;
  endfunction

  function automatic logic [5:0] idx_sp_alpha(input logic [7:0] c);
    logic [5:0] r;
    r = '0;
    if (c == cpk_pkg::ASCII_SPACE) begin
      r = {1'b1, 5'd0};
    end else if (c >= cpk_pkg::ASCII_A && c <= cpk_pkg::ASCII_Z) begin
      r = {1'b1, 5'(c - 8'd64)};
    end
    return r;
  endfunction

  logic [6:0] l0, l1;
  logic [4:0] l2;
  logic [5:0] l3, l4, l5;
  logic       all_ok;
  logic       cq_prefix;

  always_comb begin
    l0 = idx_sp_alnum(in_chars[0]);
    l1 = idx_alnum(in_chars[1]);
    l2 = idx_digit(in_chars[2]);
    l3 = idx_sp_alpha(in_chars[3]);
    l4 = idx_sp_alpha(in_chars[4]);
    l5 = idx_sp_alpha(in_chars[5]);
    all_ok = l0[6] & l1[6] & l2[4] & l3[5] & l4[5] & l5[5];
    cq_prefix = (in_chars[0] == 8'h43) && (in_chars[1] == 8'h51) && (in_chars[2] == 8'h5F);

    acc = 11'(l0[5:0]) * 11'(cpk_pkg::RADIX_LEAD) + 11'(l1[5:0]);
    k2  = l2[3:0];
    k3  = l3[4:0];
    k4  = l4[4:0];
    k5  = l5[4:0];
    n0  = in_packed - cpk_pkg::CALL_OFFSET;

    ctl.kind    = kind;
    ctl.status  = cpk_pkg::ST_OK;
    ctl.tok     = 1'b0;
    ctl.tok_val = cpk_pkg::TOK_DE;

    if (kind == cpk_pkg::KIND_ENCODE) begin
      priority if (in_chars == cpk_pkg::TEXT_DE) begin
        ctl.tok = 1'b1;
        ctl.tok_val = cpk_pkg::TOK_DE;
      end else if (in_chars == cpk_pkg::TEXT_QRZ) begin
        ctl.tok = 1'b1;
        ctl.tok_val = cpk_pkg::TOK_QRZ;
      end else if (in_chars == cpk_pkg::TEXT_CQ) begin
        ctl.tok = 1'b1;
        ctl.tok_val = cpk_pkg::TOK_CQ;
      end else if (cq_prefix) begin
        ctl.status = cpk_pkg::ST_CQ_FORM;
      end else if (!all_ok) begin
        ctl.status = cpk_pkg::ST_BAD_CHAR;
      end else begin
        ctl.status = cpk_pkg::ST_OK;
      end
    end else begin
      priority if (in_packed < 28'd3) begin
        ctl.tok = 1'b1;
        ctl.tok_val = cpk_pkg::tok_t'(in_packed[1:0]);
      end else if (in_packed < cpk_pkg::CALL_OFFSET) begin
        ctl.status = cpk_pkg::ST_UNUSED;
      end else begin
        ctl.status = cpk_pkg::ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cpk_assemble.sv =====
// Back stage logic: last digit, character mapping and result selection for
// both encode and decode. Uses cpk_pkg.
`default_nettype none

module cpk_assemble (
  input  var cpk_pkg::cpk_ctl_t ctl,
  input  wire logic [27:0]      enc_value,
  input  wire logic [10:0]      q4,
  input  wire logic [5:0]       q5,
  input  wire logic [3:0]       d2,
  input  wire logic [4:0]       d3,
  input  wire logic [4:0]       d4,
  input  wire logic [4:0]       d5,
  output logic [27:0]           out_packed,
  output logic [5:0][7:0]       out_chars,
  output cpk_pkg::status_t      status
);

  function automatic logic [7:0] chr_sp_alnum(input logic [5:0] i);
    logic [7:0] r;
    if (i == 6'd0) begin
      r = cpk_pkg::ASCII_SPACE;
    end else if (i <= 6'd10) begin
      r = 8'(i) + 8'd47;
    end else begin
      r = 8'(i) + 8'd54;
    end
    return r;
  endfunction

  function automatic logic [7:0] chr_alnum(input logic [5:0] i);
    logic [7:0] r;
    if (i < 6'd10) begin
      r = 8'(i) + cpk_pkg::ASCII_0;
    end else begin
      r = 8'(i) + 8'd55;
    end
    return r;
  endfunction

  function automatic logic [7:0] chr_sp_alpha(input logic [4:0] i);
    logic [7:0] r;
    if (i == 5'd0) begin
      r = cpk_pkg::ASCII_SPACE;
    end else begin
      r = 8'(i) + 8'd64;
    end
    return r;
  endfunction

  logic [5:0] d1;

  always_comb begin
    d1 = 6'(q4 - 11'(q5) * 11'(cpk_pkg::RADIX_LEAD));
    out_packed = '0;
    out_chars  = '0;
    status     = ctl.status;

    if (ctl.kind == cpk_pkg::KIND_ENCODE) begin
      if (ctl.status == cpk_pkg::ST_OK) begin
        out_packed = ctl.tok ? 28'(ctl.tok_val) : enc_value;
      end
    end else begin
      priority if (ctl.tok) begin
        unique case (ctl.tok_val)
          cpk_pkg::TOK_DE:  out_chars = cpk_pkg::TEXT_DE;
          cpk_pkg::TOK_QRZ: out_chars = cpk_pkg::TEXT_QRZ;
          cpk_pkg::TOK_CQ:  out_chars = cpk_pkg::TEXT_CQ;
          default:          out_chars = cpk_pkg::TEXT_BLANK;
        endcase
      end else if (ctl.status == cpk_pkg::ST_UNUSED) begin
        out_chars = cpk_pkg::TEXT_BLANK;
      end else if (q5 >= 6'd37) begin
        // lead index past its set: flag like the unused range
        status    = cpk_pkg::ST_UNUSED;
        out_chars = cpk_pkg::TEXT_BLANK;
      end else begin
        out_chars[0] = chr_sp_alnum(q5);
        out_chars[1] = chr_alnum(d1);
        out_chars[2] = 8'(d2) + cpk_pkg::ASCII_0;
        out_chars[3] = chr_sp_alpha(d3);
        out_chars[4] = chr_sp_alpha(d4);
        out_chars[5] = chr_sp_alpha(d5);
      end
    end
  end

endmodule

`default_nettype wire
